### hdl/mvc_pkg.sv
`default_nettype none
package mvc_pkg;

    localparam int MaxImageWidth  = 256;
    localparam int MaxImageHeight = 4096;
    localparam int MaxKernelSide  = 8;
    localparam int MaxChannels    = 4;

    localparam int WeightDepth = MaxKernelSide * MaxKernelSide * MaxChannels;
    localparam int LineDepth   = MaxImageWidth * MaxKernelSide * MaxChannels;
    localparam int WeightAw    = $clog2(WeightDepth);
    localparam int LineAw      = $clog2(LineDepth);
    localparam int XW          = $clog2(MaxImageWidth);
    localparam int YW          = $clog2(MaxImageHeight);
    localparam int CW          = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;
    localparam int SlotW       = (MaxKernelSide > 1) ? $clog2(MaxKernelSide) : 1;
    localparam int KW_W        = $clog2(MaxKernelSide + 1);
    localparam int IW_W        = $clog2(MaxImageWidth + 1);
    localparam int IH_W        = $clog2(MaxImageHeight + 1);
    localparam int CC_W        = $clog2(MaxChannels + 1);

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 13;

    localparam logic [CfgIdxW-1:0] RegImageWidth   = 3'd0;
    localparam logic [CfgIdxW-1:0] RegImageHeight  = 3'd1;
    localparam logic [CfgIdxW-1:0] RegKernelWidth  = 3'd2;
    localparam logic [CfgIdxW-1:0] RegKernelHeight = 3'd3;
    localparam logic [CfgIdxW-1:0] RegChannelCount = 3'd4;

    localparam logic OpLoad  = 1'b0;
    localparam logic OpImage = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic signed [15:0] sample;
        logic [7:0]         weight_index;
        logic               frame_start;
    } in_item_t;

    typedef struct packed {
        logic signed [47:0] feature_value;
        logic [7:0]         out_x;
        logic [11:0]        out_y;
        logic               last;
    } out_item_t;

endpackage
`default_nettype wire

### hdl/mvc_ram.sv
`default_nettype none
module mvc_ram #(
    parameter int Width = 16,
    parameter int Depth = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]              rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### hdl/multichannel_valid_conv2d.sv
// Load items, and image items that emit no result, are taken without stalling; an image
// item that emits walks its window, one window element per cycle through the line and
// weight memory read ports, then the product register and the accumulator.
// Throughput: one item at a time; an emitting item holds the input until its window
// sum is done and loaded, longer only while the output register is still full.
// Reset clears the position counters, control and config registers (256,16,3,3,1); memories are not cleared.
`default_nettype none
module multichannel_valid_conv2d (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [mvc_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire logic [mvc_pkg::CfgDataW-1:0] cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire mvc_pkg::in_item_t          in_data,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output mvc_pkg::out_item_t              out_data
);
    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN} state_t;

    state_t state_reg;
    logic [mvc_pkg::IW_W-1:0] iw_reg;
    logic [mvc_pkg::IH_W-1:0] ih_reg;
    logic [mvc_pkg::KW_W-1:0] kw_reg, kh_reg;
    logic [mvc_pkg::CC_W-1:0] cc_reg;
    logic [mvc_pkg::XW-1:0]   col_reg;
    logic [mvc_pkg::YW-1:0]   row_reg;
    logic [mvc_pkg::CW-1:0]   ch_reg;

    // window walk
    logic [mvc_pkg::XW-1:0]   x0_reg;
    logic [mvc_pkg::YW-1:0]   y0_reg;
    logic [mvc_pkg::KW_W-1:0] wi_reg, wj_reg;
    logic [mvc_pkg::CW-1:0]   wk_reg;
    logic [mvc_pkg::WeightAw-1:0] widx_reg;
    logic                     rd_v_reg, mul_v_reg, last_reg;
    logic signed [31:0]       prod_reg;
    logic signed [47:0]       acc_reg;

    logic [15:0] wrd, lrd;
    logic        w_we, l_we;
    logic [mvc_pkg::WeightAw-1:0] w_waddr;
    logic [mvc_pkg::LineAw-1:0]   l_waddr, l_raddr;

    logic accept;
    logic [mvc_pkg::XW-1:0] cx;
    logic [mvc_pkg::YW-1:0] cy;
    logic [mvc_pkg::CW-1:0] cc;
    logic emit;
    logic [mvc_pkg::XW:0]   x1;
    logic [mvc_pkg::YW:0]   y1;
    logic [mvc_pkg::CW:0]   c1;
    logic [mvc_pkg::XW-1:0] px;
    logic [mvc_pkg::YW-1:0] py;
    logic walk_end;
    logic out_load;

    function automatic logic [mvc_pkg::LineAw-1:0] laddr(
        input logic [mvc_pkg::YW-1:0] y,
        input logic [mvc_pkg::XW-1:0] x,
        input logic [mvc_pkg::CW-1:0] c
    );
        laddr = {y[mvc_pkg::SlotW-1:0], x, c};
    endfunction

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);

    // window sum done and the output register free or emptying this cycle
    assign out_load = (state_reg == S_DRAIN) && !rd_v_reg && !mul_v_reg
        && (!out_valid || !out_stall);

    always_comb
    begin
        if (in_data.frame_start)
        begin
            cx = '0;
            cy = '0;
            cc = '0;
        end
        else
        begin
            cx = col_reg;
            cy = row_reg;
            cc = ch_reg;
        end
        x1 = {1'b0, cx} + 1'b1;
        y1 = {1'b0, cy} + 1'b1;
        c1 = {1'b0, cc} + 1'b1;
        emit = ({{(mvc_pkg::CC_W-mvc_pkg::CW-1){1'b0}}, c1} >= cc_reg)
            && ({{(mvc_pkg::IW_W-mvc_pkg::XW-1){1'b0}}, x1} >= mvc_pkg::IW_W'(kw_reg))
            && ({{(mvc_pkg::IH_W-mvc_pkg::YW-1){1'b0}}, y1} >= mvc_pkg::IH_W'(kh_reg));
        px = mvc_pkg::XW'({1'b0, x0_reg} + mvc_pkg::IW_W'(wi_reg));
        py = mvc_pkg::YW'({1'b0, y0_reg} + mvc_pkg::IH_W'(wj_reg));
        walk_end = (wi_reg == kw_reg - 1'b1) && (wj_reg == kh_reg - 1'b1)
            && ({1'b0, wk_reg} == mvc_pkg::CC_W'(cc_reg - 1'b1));
    end

    assign w_we    = accept && (in_data.opcode == mvc_pkg::OpLoad);
    assign w_waddr = in_data.weight_index[mvc_pkg::WeightAw-1:0];
    assign l_we    = accept && (in_data.opcode == mvc_pkg::OpImage);
    assign l_waddr = laddr(cy, cx, cc);
    assign l_raddr = laddr(py, px, wk_reg);

    mvc_ram #(.Width(16), .Depth(mvc_pkg::WeightDepth)) u_wram (
        .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(in_data.sample),
        .raddr(widx_reg), .rdata(wrd)
    );

    mvc_ram #(.Width(16), .Depth(mvc_pkg::LineDepth)) u_lram (
        .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(in_data.sample),
        .raddr(l_raddr), .rdata(lrd)
    );

    function automatic logic [12:0] clampv(input logic [12:0] v, input logic [12:0] hi);
        if (v == '0) clampv = 13'd1;
        else if (v > hi) clampv = hi;
        else clampv = v;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            iw_reg    <= mvc_pkg::IW_W'(256);
            ih_reg    <= mvc_pkg::IH_W'(16);
            kw_reg    <= mvc_pkg::KW_W'(3);
            kh_reg    <= mvc_pkg::KW_W'(3);
            cc_reg    <= mvc_pkg::CC_W'(1);
            col_reg   <= '0;
            row_reg   <= '0;
            ch_reg    <= '0;
            rd_v_reg  <= 1'b0;
            mul_v_reg <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    mvc_pkg::RegImageWidth:
                        iw_reg <= mvc_pkg::IW_W'(clampv(cfg_data, 13'(mvc_pkg::MaxImageWidth)));
                    mvc_pkg::RegImageHeight:
                        ih_reg <= mvc_pkg::IH_W'(clampv(cfg_data, 13'(mvc_pkg::MaxImageHeight)));
                    mvc_pkg::RegKernelWidth:
                        kw_reg <= mvc_pkg::KW_W'(clampv(cfg_data, 13'(mvc_pkg::MaxKernelSide)));
                    mvc_pkg::RegKernelHeight:
                        kh_reg <= mvc_pkg::KW_W'(clampv(cfg_data, 13'(mvc_pkg::MaxKernelSide)));
                    mvc_pkg::RegChannelCount:
                        cc_reg <= mvc_pkg::CC_W'(clampv(cfg_data, 13'(mvc_pkg::MaxChannels)));
                    default: ;
                endcase
            end

            rd_v_reg  <= (state_reg == S_RUN);
            mul_v_reg <= rd_v_reg;

            if (out_load)
            begin
                out_valid <= 1'b1;
                out_data.feature_value <= acc_reg;
                out_data.out_x <= 8'(x0_reg);
                out_data.out_y <= 12'(y0_reg);
                out_data.last  <= last_reg;
            end
            else if (!out_stall)
            begin
                out_valid <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (l_we)
                    begin
                        if ({{(mvc_pkg::CC_W-mvc_pkg::CW-1){1'b0}}, c1} >= cc_reg)
                        begin
                            ch_reg <= '0;
                            if ({{(mvc_pkg::IW_W-mvc_pkg::XW-1){1'b0}}, x1} >= iw_reg)
                            begin
                                col_reg <= '0;
                                row_reg <= ({{(mvc_pkg::IH_W-mvc_pkg::YW-1){1'b0}}, y1} >= ih_reg)
                                    ? '0 : y1[mvc_pkg::YW-1:0];
                            end
                            else
                            begin
                                col_reg <= x1[mvc_pkg::XW-1:0];
                                row_reg <= cy;
                            end
                        end
                        else
                        begin
                            ch_reg  <= c1[mvc_pkg::CW-1:0];
                            col_reg <= cx;
                            row_reg <= cy;
                        end
                        if (emit)
                        begin
                            state_reg <= S_RUN;
                            x0_reg   <= mvc_pkg::XW'(x1 - (mvc_pkg::XW+1)'(kw_reg));
                            y0_reg   <= mvc_pkg::YW'(y1 - (mvc_pkg::YW+1)'(kh_reg));
                            last_reg <= ({{(mvc_pkg::IW_W-mvc_pkg::XW-1){1'b0}}, x1} >= iw_reg)
                                && ({{(mvc_pkg::IH_W-mvc_pkg::YW-1){1'b0}}, y1} >= ih_reg);
                            wi_reg   <= '0;
                            wj_reg   <= '0;
                            wk_reg   <= '0;
                            widx_reg <= '0;
                            acc_reg  <= '0;
                        end
                    end
                end
                S_RUN:
                begin
                    widx_reg <= widx_reg + 1'b1;
                    if (walk_end)
                    begin
                        state_reg <= S_DRAIN;
                    end
                    else if (wi_reg == kw_reg - 1'b1)
                    begin
                        wi_reg <= '0;
                        if (wj_reg == kh_reg - 1'b1)
                        begin
                            wj_reg <= '0;
                            wk_reg <= wk_reg + 1'b1;
                        end
                        else
                        begin
                            wj_reg <= wj_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        wi_reg <= wi_reg + 1'b1;
                    end
                end
                S_DRAIN:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase

            if (rd_v_reg)
            begin
                prod_reg <= $signed(lrd) * $signed(wrd);
            end
            if (mul_v_reg)
            begin
                acc_reg <= acc_reg + 48'(prod_reg);
            end
        end
    end
endmodule
`default_nettype wire
